### rtl/fp4a_pkg.sv
// Shared constants and stage payload types for the fused four-operand fp32 adder.
// No dependencies; every other rtl file imports this package.
`default_nettype none
package fp4a_pkg;
    localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
    localparam logic [31:0] PINF_BITS  = 32'h7F80_0000;
    localparam logic [31:0] NINF_BITS  = 32'hFF80_0000;
    localparam logic [23:0] HIDDEN_BIT = 24'h80_0000;
    localparam logic [22:0] FRAC_MASK  = 23'h7F_FFFF;
    localparam logic [3:0]  ROUND_MASK = 4'hF;
    localparam logic [7:0]  EXP_ALL1   = 8'hFF;
    localparam logic [4:0]  NORM_MSB   = 5'd27;

    // unpacked operands, reference chosen
    typedef struct packed {
        logic             valid;
        logic             byp;
        logic [31:0]      byp_val;
        logic             sref;
        logic [7:0]       maxe;
        logic [3:0]       sgn;
        logic [3:0][7:0]  ex;
        logic [3:0][23:0] man;
    } t_unp;

    // aligned signed terms and sticky flags
    typedef struct packed {
        logic             valid;
        logic             byp;
        logic [31:0]      byp_val;
        logic             sref;
        logic [7:0]       maxe;
        logic [3:0][28:0] term;
        logic             pos_st;
        logic             neg_st;
    } t_aln;

    // signed sum
    typedef struct packed {
        logic        valid;
        logic        byp;
        logic [31:0] byp_val;
        logic        sref;
        logic [7:0]  maxe;
        logic [31:0] acc;
    } t_acc;

    // magnitude and leading-one position
    typedef struct packed {
        logic        valid;
        logic        byp;
        logic [31:0] byp_val;
        logic        rs;
        logic [7:0]  maxe;
        logic [30:0] mag;
        logic [4:0]  msb;
    } t_mag;
endpackage
`default_nettype wire

### rtl/fp4a_align.sv
// Stages 1-2: unpack, special detection, reference selection and alignment.
// Depends on fp4a_pkg.
`default_nettype none
module fp4a_align import fp4a_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire  [31:0] i_operand_a,
    input  wire  [31:0] i_operand_b,
    input  wire  [31:0] i_operand_c,
    input  wire  [31:0] i_operand_d,
    output t_aln        o_aln
);
    t_unp r_unp, n_unp;
    t_aln r_aln, n_aln;

    always_comb begin
        logic [3:0][31:0] w;
        logic nan, pinf, ninf, found;
        logic [1:0] refi;
        n_unp = '0;
        w = {i_operand_d, i_operand_c, i_operand_b, i_operand_a};
        nan = 1'b0; pinf = 1'b0; ninf = 1'b0; found = 1'b0; refi = 2'd0;
        n_unp.valid = i_valid;
        for (int i = 0; i < 4; i++) begin
            n_unp.sgn[i] = w[i][31];
            n_unp.ex[i]  = w[i][30:23];
            n_unp.man[i] = (w[i][30:23] == 8'd0) ? 24'd0 : (HIDDEN_BIT | {1'b0, w[i][22:0]});
            if (w[i][30:23] == EXP_ALL1) begin
                if ((w[i][22:0] & FRAC_MASK) != 23'd0) nan = 1'b1;
                else if (!w[i][31]) pinf = 1'b1;
                else ninf = 1'b1;
            end
            // first strictly larger exponent wins
            if (w[i][30:23] != 8'd0 && (!found || w[i][30:23] > n_unp.maxe)) begin
                found = 1'b1;
                n_unp.maxe = w[i][30:23];
                refi = 2'(i);
            end
        end
        n_unp.sref = w[refi][31];
        n_unp.byp = 1'b1;
        if (nan || (pinf && ninf)) n_unp.byp_val = QNAN_BITS;
        else if (pinf)             n_unp.byp_val = PINF_BITS;
        else if (ninf)             n_unp.byp_val = NINF_BITS;
        else if (!found)           n_unp.byp_val = 32'd0;
        else                       n_unp.byp = 1'b0;
    end

    always_comb begin
        logic [7:0]  s;
        logic [26:0] m, al;
        logic        st;
        n_aln = '0;
        n_aln.valid   = r_unp.valid;
        n_aln.byp     = r_unp.byp;
        n_aln.byp_val = r_unp.byp_val;
        n_aln.sref    = r_unp.sref;
        n_aln.maxe    = r_unp.maxe;
        for (int i = 0; i < 4; i++) begin
            s = r_unp.maxe - r_unp.ex[i];
            m = {r_unp.man[i], 3'b000};
            if (s >= 8'd27) begin
                al = 27'd0;
                st = 1'b1;
            end else begin
                al = m >> s[4:0];
                st = (m & ((27'd1 << s[4:0]) - 27'd1)) != 27'd0;
            end
            if (r_unp.man[i] != 24'd0) begin
                if (r_unp.sgn[i] == r_unp.sref) begin
                    n_aln.term[i] = {1'b0, al, 1'b0};
                    if (st) n_aln.pos_st = 1'b1;
                end else begin
                    n_aln.term[i] = -{1'b0, al, 1'b0};
                    if (st) n_aln.neg_st = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_unp <= n_unp;
        r_aln <= n_aln;
        if (!i_rst_n) begin
            r_unp.valid <= 1'b0;
            r_aln.valid <= 1'b0;
        end
    end

    assign o_aln = r_aln;
endmodule
`default_nettype wire

### rtl/fp4a_sum.sv
// Stages 3-5: add the aligned terms and sticky, take magnitude, find the leading one.
// Depends on fp4a_pkg.
`default_nettype none
module fp4a_sum import fp4a_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_aln  i_aln,
    output t_mag  o_mag
);
    t_acc r_acc, n_acc;
    t_mag r_abs, n_abs;
    t_mag r_lzc, n_lzc;

    always_comb begin
        logic [31:0] adj;
        n_acc.valid   = i_aln.valid;
        n_acc.byp     = i_aln.byp;
        n_acc.byp_val = i_aln.byp_val;
        n_acc.sref    = i_aln.sref;
        n_acc.maxe    = i_aln.maxe;
        if (i_aln.pos_st && !i_aln.neg_st)      adj = 32'd1;
        else if (i_aln.neg_st && !i_aln.pos_st) adj = 32'hFFFF_FFFF;
        else                                    adj = 32'd0;
        n_acc.acc = 32'($signed(i_aln.term[0])) + 32'($signed(i_aln.term[1]))
                  + 32'($signed(i_aln.term[2])) + 32'($signed(i_aln.term[3])) + adj;
    end

    always_comb begin
        logic [31:0] a;
        n_abs = '0;
        n_abs.valid   = r_acc.valid;
        n_abs.byp     = r_acc.byp;
        n_abs.byp_val = r_acc.byp_val;
        n_abs.maxe    = r_acc.maxe;
        n_abs.rs      = r_acc.sref ^ r_acc.acc[31];
        a = r_acc.acc[31] ? -r_acc.acc : r_acc.acc;
        n_abs.mag = a[30:0];
        // exact cancellation
        if (!r_acc.byp && r_acc.acc == 32'd0) begin
            n_abs.byp     = 1'b1;
            n_abs.byp_val = 32'd0;
        end
    end

    always_comb begin
        n_lzc = r_abs;
        n_lzc.msb = 5'd0;
        for (int i = 0; i < 31; i++)
            if (r_abs.mag[i]) n_lzc.msb = 5'(i);
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_abs <= n_abs;
        r_lzc <= n_lzc;
        if (!i_rst_n) begin
            r_acc.valid <= 1'b0;
            r_abs.valid <= 1'b0;
            r_lzc.valid <= 1'b0;
        end
    end

    assign o_mag = r_lzc;
endmodule
`default_nettype wire

### rtl/fp4a_norm.sv
// Stage 6: normalize with sticky, round to nearest even, pack and clamp.
// Depends on fp4a_pkg.
`default_nettype none
module fp4a_norm import fp4a_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_mag        i_mag,
    output logic        o_strobe,
    output logic [31:0] o_total
);
    logic        r_strobe;
    logic [31:0] r_total, n_total;

    always_comb begin
        logic [27:0]        nm;
        logic [4:0]         sh;
        logic signed [10:0] e;
        logic [3:0]         tr;
        logic [24:0]        mt;
        logic               inc;
        sh = NORM_MSB - i_mag.msb;
        e  = $signed({3'b000, i_mag.maxe}) + $signed({6'b0, i_mag.msb})
           - $signed({6'b0, NORM_MSB});
        if (i_mag.msb == 5'd29) begin
            nm = i_mag.mag[29:2] | {27'd0, |i_mag.mag[2:0]};
        end else if (i_mag.msb == 5'd28) begin
            nm = i_mag.mag[28:1] | {27'd0, i_mag.mag[0]};
        end else begin
            nm = i_mag.mag[27:0] << sh;
            // drop the bit that came up from the lowest sum position
            if (sh >= 5'd4) nm = nm & ~(28'd1 << sh);
        end
        tr  = nm[3:0] & ROUND_MASK;
        inc = (tr > 4'd8) || (tr == 4'd8 && nm[4]);
        mt  = {1'b0, nm[27:4]} + {24'd0, inc};
        if (mt[24]) begin
            mt = mt >> 1;
            e  = e + 11'sd1;
        end
        if (i_mag.byp)           n_total = i_mag.byp_val;
        else if (e <= 11'sd0)    n_total = 32'd0;
        else if (e >= 11'sd255)  n_total = {i_mag.rs, PINF_BITS[30:0]};
        else                     n_total = {i_mag.rs, e[7:0], mt[22:0] & FRAC_MASK};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_mag.valid;
        end
        r_total <= n_total;
    end

    assign o_strobe = r_strobe;
    assign o_total  = r_total;
endmodule
`default_nettype wire

### rtl/fused_four_operand_fp32_adder_unit.sv
// Fused four-operand fp32 adder: the start beat passes through the stage registers to o_strobe.
// Throughput one beat per cycle; busy stays low, every stage advances each cycle.
// The six stage registers set the latency; the align shift is 27 bits wide.
// Synchronous active-low reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall: each result is shown on o_total for one cycle with o_strobe.
// Depends on fp4a_pkg, fp4a_align, fp4a_sum, fp4a_norm.
`default_nettype none
module fused_four_operand_fp32_adder_unit import fp4a_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [31:0] i_operand_a,
    input  wire  [31:0] i_operand_b,
    input  wire  [31:0] i_operand_c,
    input  wire  [31:0] i_operand_d,
    output logic        o_strobe,
    output logic [31:0] o_total
);
    t_aln w_aln;
    t_mag w_mag;

    // fully pipelined: never hold off a beat
    assign busy = 1'b0;

    // unpack, pick the reference operand, align the other three
    fp4a_align u_align (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_operand_c (i_operand_c),
        .i_operand_d (i_operand_d),
        .o_aln       (w_aln)
    );

    // sum, magnitude, leading-one search
    fp4a_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_aln   (w_aln),
        .o_mag   (w_mag)
    );

    // normalize, round, pack into the output register
    fp4a_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mag    (w_mag),
        .o_strobe (o_strobe),
        .o_total  (o_total)
    );
endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the fused four-operand fp32 adder unit.
// Drives operand beats with random gaps and checks each o_total against a local predictor.
// Depends on fused_four_operand_fp32_adder_unit only.
`timescale 1ns / 1ps
module tb;
    localparam int LATENCY     = 6;
    localparam int WATCH_LIMIT = 20000;
    localparam int N_RANDOM    = 900;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] PINF = 32'h7F80_0000;
    localparam logic [31:0] NINF = 32'hFF80_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_operand_a, i_operand_b, i_operand_c, i_operand_d;
    logic        o_strobe;
    logic [31:0] o_total;

    logic [31:0] sum_q[$];
    int          n_err;
    int          idle_cycles;

    fused_four_operand_fp32_adder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .i_operand_c(i_operand_c),
        .i_operand_d(i_operand_d),
        .o_strobe   (o_strobe),
        .o_total    (o_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Predict the rounded fused sum of four binary32 words.
    function automatic logic [31:0] fused_total(input logic [3:0][31:0] w);
        logic        nan_seen, pinf_seen, ninf_seen;
        logic [3:0]  sgn;
        logic [7:0]  ex[4];
        logic [23:0] man[4];
        int          maxe, ref_idx, shamt, pos_st, neg_st, e, msb, nsh;
        logic [63:0] m, al, mag;
        longint      acc;
        logic        lost, same_sign, rs;
        logic [3:0]  rnd;
        logic [31:0] mt;
        nan_seen = 0; pinf_seen = 0; ninf_seen = 0;
        for (int i = 0; i < 4; i++) begin
            sgn[i] = w[i][31];
            ex[i]  = w[i][30:23];
            man[i] = {1'b0, w[i][22:0]};
            if (ex[i] == 8'hFF) begin
                if (man[i] != 0) nan_seen = 1;
                else if (!sgn[i]) pinf_seen = 1;
                else ninf_seen = 1;
            end
        end
        if (nan_seen || (pinf_seen && ninf_seen)) return QNAN;
        if (pinf_seen) return PINF;
        if (ninf_seen) return NINF;
        // flush subnormals, restore hidden bit
        for (int i = 0; i < 4; i++)
            man[i] = (ex[i] == 0) ? 24'd0 : (man[i] | 24'h80_0000);
        maxe = -1; ref_idx = 0;
        for (int i = 0; i < 4; i++)
            if (man[i] != 0 && int'(ex[i]) > maxe) begin
                maxe = ex[i];
                ref_idx = i;
            end
        if (maxe < 0) return 32'd0;
        pos_st = 0; neg_st = 0; acc = 0;
        for (int i = 0; i < 4; i++) begin
            if (man[i] == 0) continue;
            shamt = maxe - int'(ex[i]);
            m = 64'(man[i]) << 3;
            if (shamt >= 27) begin
                al = 0; lost = 1;
            end else if (shamt > 0) begin
                al = m >> shamt;
                lost = (m & ((64'd1 << shamt) - 1)) != 0;
            end else begin
                al = m; lost = 0;
            end
            same_sign = (sgn[i] == sgn[ref_idx]);
            if (lost && i != ref_idx) begin
                if (same_sign) pos_st++;
                else neg_st++;
            end
            if (same_sign) acc += longint'(al << 1);
            else acc -= longint'(al << 1);
        end
        // merge one signed sticky at the lowest bit
        if (pos_st > 0 && neg_st == 0) acc += 1;
        else if (neg_st > 0 && pos_st == 0) acc -= 1;
        if (acc == 0) return 32'd0;
        rs = sgn[ref_idx];
        if (acc < 0) begin
            rs = ~rs;
            mag = 64'(-acc);
        end else begin
            mag = 64'(acc);
        end
        e = maxe; msb = 0;
        for (int i = 0; i < 63; i++)
            if (mag[i]) msb = i;
        nsh = 27 - msb;
        if (nsh < 0) begin
            while (mag >= (64'd1 << 28)) begin
                mag = (mag >> 1) | (mag & 64'd1);
                e++;
            end
        end else if (nsh > 0) begin
            mag = mag << nsh;
            e -= nsh;
            if (nsh >= 4) mag[nsh] = 1'b0;
        end
        rnd = mag[3:0];
        mt  = mag[35:4];
        if (rnd > 4'd8 || (rnd == 4'd8 && mt[0])) mt++;
        if (mt >= 32'h100_0000) begin
            mt = mt >> 1;
            e++;
        end
        if (e <= 0) return 32'd0;
        if (e >= 255) return {rs, 31'd0} | PINF;
        return {rs, 8'(e), mt[22:0]};
    endfunction

    // Random binary32 word, biased toward narrow exponent spread and specials.
    function automatic logic [31:0] rand_word(input int base_exp);
        int sel;
        sel = $urandom_range(99);
        if (sel < 3) return {1'($urandom_range(1)), 8'hFF, 23'd0};
        if (sel < 5) return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
        if (sel < 9) return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
        if (sel < 25) return $urandom;
        return {1'($urandom_range(1)),
                8'(base_exp - int'($urandom_range(0, 30)) < 1 ? 1 :
                   base_exp - int'($urandom_range(0, 30))),
                23'($urandom)};
    endfunction

    // Drive one beat and hold it until accepted; optionally add a gap first.
    task automatic send_beat(input logic [3:0][31:0] w, input bit gaps);
        int gap;
        if (gaps) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(8, 40) :
                  ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start       <= 1'b1;
        i_operand_a <= w[0];
        i_operand_b <= w[1];
        i_operand_c <= w[2];
        i_operand_d <= w[3];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sum_q.push_back(fused_total(w));
    endtask

    // Check every strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (sum_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", o_total);
            end else begin
                if (o_total !== sum_q[0]) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("total mismatch: expected %h actual %h", sum_q[0], o_total);
                end
                void'(sum_q.pop_front());
            end
        end
    end

    // Watchdog: count cycles with no accepted beat on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Directed table: operands and, where obvious, the expected total.
    typedef struct {
        logic [3:0][31:0] w;
        bit               has_exp;
        logic [31:0]      exp_total;
    } t_row;

    t_row dir_rows[$];

    task automatic add_row(input logic [31:0] a, b, c, d,
                           input bit has_exp, input logic [31:0] exp_total);
        t_row r;
        r.w = {d, c, b, a};
        r.has_exp = has_exp;
        r.exp_total = exp_total;
        dir_rows.push_back(r);
    endtask

    initial begin
        logic [3:0][31:0] w;
        int base_exp, drain;
        n_err = 0;
        idle_cycles = 0;
        start = 1'b0;
        i_operand_a = '0; i_operand_b = '0; i_operand_c = '0; i_operand_d = '0;
        i_rst_n = 1'b0;

        add_row(32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0);                     // all zero
        add_row(32'h8000_0001, 32'h007F_FFFF, 32'h0, 32'h8000_0000, 1, 32'h0); // subnormals
        add_row(32'h7FC0_0000, 32'h3F80_0000, 32'h0, 32'h0, 1, QNAN);      // NaN
        add_row(32'hFFFF_FFFF, 32'h7F80_0000, 32'h0, 32'h0, 1, QNAN);      // NaN with inf
        add_row(32'h7F80_0000, 32'hFF80_0000, 32'h0, 32'h0, 1, QNAN);      // both infinities
        add_row(32'h7F80_0000, 32'hFF7F_FFFF, 32'h3F80_0000, 32'h0, 1, PINF);
        add_row(32'h3F80_0000, 32'hFF80_0000, 32'hFF80_0000, 32'h0, 1, NINF);
        add_row(32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000, 32'hC000_0000, 1, 32'h0);
        add_row(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1, 32'h4080_0000);
        add_row(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1, PINF);
        add_row(32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'h0, 32'h0, 1, NINF);       // overflow
        add_row(32'h0080_0000, 32'h8080_0001, 32'h0, 32'h0, 1, 32'h0);      // underflow
        add_row(32'h0080_0000, 32'h0080_0000, 32'h0, 32'h0, 1, 32'h0100_0000);
        // rows below are predictor-checked
        add_row(32'h3F80_0000, 32'h3380_0001, 32'h3380_0000, 32'h0, 0, 0); // positive sticky
        add_row(32'h3F80_0000, 32'hB380_0001, 32'hB300_0001, 32'h0, 0, 0); // negative sticky
        add_row(32'h3F80_0000, 32'h3380_0001, 32'hB380_0001, 32'h0, 0, 0); // mixed sticky
        add_row(32'h3F80_0000, 32'h2000_0000, 32'hA000_0000, 32'h0, 0, 0); // far shift
        add_row(32'h3F80_0001, 32'hBF80_0000, 32'h3300_0000, 32'h0, 0, 0); // deep left shift
        add_row(32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 0, 0);
        add_row(32'h3F80_0000, 32'h3380_0000, 32'h0, 32'h0, 0, 0);         // tie to even
        add_row(32'h3F80_0001, 32'h3380_0000, 32'h0, 32'h0, 0, 0);         // tie, round up
        add_row(32'h4000_0000, 32'h4000_0000, 32'hC040_0000, 32'h0, 0, 0); // first max ref
        add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, QNAN);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h2AAA_AAAA, 32'hD555_5555, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: typed-in values must agree with the predictor too
        foreach (dir_rows[k]) begin
            if (dir_rows[k].has_exp && fused_total(dir_rows[k].w) !== dir_rows[k].exp_total) begin
                n_err++;
                if (n_err <= 10)
                    $display("row %0d table %h predictor %h", k, dir_rows[k].exp_total,
                             fused_total(dir_rows[k].w));
            end
            send_beat(dir_rows[k].w, k > 12);
        end

        // random part: stretches with no gaps alternate with gapped ones
        for (int n = 0; n < N_RANDOM; n++) begin
            base_exp = $urandom_range(1, 254);
            for (int j = 0; j < 4; j++) w[j] = rand_word(base_exp);
            send_beat(w, (n / 100) % 2 == 1);
        end
        start <= 1'b0;

        drain = 0;
        while (sum_q.size() != 0 && drain < 100 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (n_err == 0 && sum_q.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

### fused_four_operand_fp32_adder_unit.f
rtl/fp4a_pkg.sv
rtl/fp4a_align.sv
rtl/fp4a_sum.sv
rtl/fp4a_norm.sv
rtl/fused_four_operand_fp32_adder_unit.sv
bench/tb.sv
